@@ rtl/core/tremolo_amplitude_modulator_assert.svh @@
// ----------------------------------------------------------------------------
// tremolo_amplitude_modulator_assert
// Assertion macros used by the tremolo datapath (trem_dp).
// ----------------------------------------------------------------------------
`ifndef TREMOLO_AMPLITUDE_MODULATOR_ASSERT_SVH
`define TREMOLO_AMPLITUDE_MODULATOR_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define TAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TAM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/trem_pkg.sv @@
// ----------------------------------------------------------------------------
// trem_pkg
// Shared types, constants and command codes of the tremolo modulator.
// ----------------------------------------------------------------------------
package trem_pkg;

    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF    = 24;

    // Shared multiplier: signed operands, full product.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam int PHASE_W = 32;
    localparam int STEP_W  = 31;
    localparam int DEPTH_W = 16;
    localparam int Q30_W   = 31;
    localparam int SIN_W   = 17;
    localparam int GAIN_W  = 17;

    localparam logic [Q30_W-1:0]   Q30_ONE   = 31'h4000_0000;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'd32768;
    localparam logic [DEPTH_W-1:0] DEPTH_RST = 16'd16384;

    // Taylor coefficients of sin(pi/2 * x) in Q30.
    localparam logic [Q30_W-1:0] C1 = 31'd1686629713;
    localparam logic [Q30_W-1:0] C3 = 31'd693598668;
    localparam logic [Q30_W-1:0] C5 = 31'd85569306;
    localparam logic [Q30_W-1:0] C7 = 31'd5026995;
    localparam logic [Q30_W-1:0] C9 = 31'd172272;

    typedef enum logic
    {
        REG_PHASE_STEP = 1'b0,
        REG_DEPTH      = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0]
    {
        MUL_NONE,
        MUL_X_X,
        MUL_X2_C9,
        MUL_X2_T,
        MUL_X_T,
        MUL_D_SIN,
        MUL_SMP_GAIN
    } mul_op_t;

    typedef enum logic [3:0]
    {
        WB_NONE,
        WB_X2,
        WB_T7,
        WB_T5,
        WB_T3,
        WB_T1,
        WB_SIN,
        WB_GAIN,
        WB_OUT
    } wb_op_t;

    typedef enum logic [4:0]
    {
        ST_IDLE,
        ST_M_SQR,
        ST_W_SQR,
        ST_M_C9,
        ST_W_C9,
        ST_M_H5,
        ST_W_H5,
        ST_M_H3,
        ST_W_H3,
        ST_M_H1,
        ST_W_H1,
        ST_M_SIN,
        ST_W_SIN,
        ST_M_GAIN,
        ST_W_GAIN,
        ST_M_OUT,
        ST_W_OUT
    } state_t;

    typedef struct packed
    {
        logic    load;
        mul_op_t mul_op;
        wb_op_t  wb_op;
    } cmd_t;

endpackage

@@ rtl/core/tremolo_amplitude_modulator.sv @@
// ----------------------------------------------------------------------------
// tremolo_amplitude_modulator
// Sine LFO tremolo: scales each audio sample by a depth-weighted sine gain.
// ----------------------------------------------------------------------------
// Each input item (one sample plus a block_start flag in tuser) is accepted
// only while the sequencer is idle; its result reaches the output register
// after eight products on one shared 33x33 multiplier (sine polynomial,
// gain, sample scaling), each taking a multiply step and a write-back
// step. The next item is accepted only once the sequencer is back in idle,
// so items never overlap in the datapath. The result sits in an
// output register, so the next item is accepted while it waits; if it is
// still waiting when the next result is ready, the sequencer holds in its
// last step. block_start restarts the LFO phase at zero for that sample.
// Registers: phase_step at 0x0, depth at 0x4.
module tremolo_amplitude_modulator
#(
    parameter int SINE_ADDR_BITS = trem_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS    = trem_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_in
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // block_start
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // sample_out
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata
);
    import trem_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    logic [STEP_W-1:0]      phase_step;
    logic [DEPTH_W-1:0]     depth;
    logic [SAMPLE_BITS-1:0] sample_out;
    cmd_t                   cmd;

    trem_cfg u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .phase_step (phase_step),
        .depth      (depth)
    );

    trem_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    trem_dp
    #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample_in   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .block_start (s_axis_tuser),
        .phase_step  (phase_step),
        .depth       (depth),
        .sample_out  (sample_out)
    );

    assign m_axis_tdata = TDATA_W'(sample_out);

endmodule

@@ rtl/core/trem_cfg.sv @@
// ----------------------------------------------------------------------------
// trem_cfg
// APB register file: LFO phase step and modulation depth.
// ----------------------------------------------------------------------------
module trem_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [trem_pkg::STEP_W-1:0]  phase_step,
    output logic [trem_pkg::DEPTH_W-1:0] depth
);
    import trem_pkg::*;

    logic [STEP_W-1:0]  step_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            depth_reg <= DEPTH_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_PHASE_STEP: step_reg  <= pwdata[STEP_W-1:0];
                REG_DEPTH:      depth_reg <= pwdata[DEPTH_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PHASE_STEP: prdata = {{(32-STEP_W){1'b0}}, step_reg};
            REG_DEPTH:      prdata = {{(32-DEPTH_W){1'b0}}, depth_reg};
            default:        prdata = '0;
        endcase
    end

    assign phase_step = step_reg;
    assign depth      = depth_reg;

endmodule

@@ rtl/core/trem_ctrl.sv @@
// ----------------------------------------------------------------------------
// trem_ctrl
// Sequencer: steps the shared multiplier through sine, gain and output.
// ----------------------------------------------------------------------------
module trem_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output trem_pkg::cmd_t      cmd
);
    import trem_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.mul_op     = MUL_NONE;
        cmd.wb_op      = WB_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_M_SQR;
                end
            end
            ST_M_SQR:
            begin
                cmd.mul_op = MUL_X_X;
                state_next = ST_W_SQR;
            end
            ST_W_SQR:
            begin
                cmd.wb_op  = WB_X2;
                state_next = ST_M_C9;
            end
            ST_M_C9:
            begin
                cmd.mul_op = MUL_X2_C9;
                state_next = ST_W_C9;
            end
            ST_W_C9:
            begin
                cmd.wb_op  = WB_T7;
                state_next = ST_M_H5;
            end
            ST_M_H5:
            begin
                cmd.mul_op = MUL_X2_T;
                state_next = ST_W_H5;
            end
            ST_W_H5:
            begin
                cmd.wb_op  = WB_T5;
                state_next = ST_M_H3;
            end
            ST_M_H3:
            begin
                cmd.mul_op = MUL_X2_T;
                state_next = ST_W_H3;
            end
            ST_W_H3:
            begin
                cmd.wb_op  = WB_T3;
                state_next = ST_M_H1;
            end
            ST_M_H1:
            begin
                cmd.mul_op = MUL_X2_T;
                state_next = ST_W_H1;
            end
            ST_W_H1:
            begin
                cmd.wb_op  = WB_T1;
                state_next = ST_M_SIN;
            end
            ST_M_SIN:
            begin
                cmd.mul_op = MUL_X_T;
                state_next = ST_W_SIN;
            end
            ST_W_SIN:
            begin
                cmd.wb_op  = WB_SIN;
                state_next = ST_M_GAIN;
            end
            ST_M_GAIN:
            begin
                cmd.mul_op = MUL_D_SIN;
                state_next = ST_W_GAIN;
            end
            ST_W_GAIN:
            begin
                cmd.wb_op  = WB_GAIN;
                state_next = ST_M_OUT;
            end
            ST_M_OUT:
            begin
                cmd.mul_op = MUL_SMP_GAIN;
                state_next = ST_W_OUT;
            end
            ST_W_OUT:
            begin
                // hold the product until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.wb_op      = WB_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/trem_dp.sv @@
// ----------------------------------------------------------------------------
// trem_dp
// Datapath: phase accumulator, shared 33x33 multiplier and write-back logic.
// ----------------------------------------------------------------------------
`include "tremolo_amplitude_modulator_assert.svh"

module trem_dp
#(
    parameter int SINE_ADDR_BITS = trem_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS    = trem_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  trem_pkg::cmd_t               cmd,
    input  logic [SAMPLE_BITS-1:0]       sample_in,
    input  logic                         block_start,
    input  logic [trem_pkg::STEP_W-1:0]  phase_step,
    input  logic [trem_pkg::DEPTH_W-1:0] depth,
    output logic [SAMPLE_BITS-1:0]       sample_out
);
    import trem_pkg::*;

    localparam int QB = SINE_ADDR_BITS - 2;
    localparam logic [QB:0] QUART = {1'b1, {QB{1'b0}}};
    localparam logic signed [32:0] Y_HI =
        33'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [32:0] Y_LO = ~Y_HI;

    logic [PHASE_W-1:0]            phase_reg;
    logic [Q30_W-1:0]              x_reg;
    logic [Q30_W-1:0]              x2_reg;
    logic [Q30_W-1:0]              t_reg;
    logic                          neg_reg;
    logic [DEPTH_W-1:0]            d_reg;
    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic signed [SIN_W-1:0]       sin_reg;
    logic signed [GAIN_W-1:0]      gain_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic [SAMPLE_BITS-1:0]        out_reg;

    logic [PHASE_W-1:0]            phase_base;
    logic [SINE_ADDR_BITS-1:0]     addr;
    logic [QB:0]                   num;
    logic [Q30_W-1:0]              x_next;
    logic signed [MUL_W-1:0]       op_a;
    logic signed [MUL_W-1:0]       op_b;
    logic [Q30_W-1:0]              coef;
    logic [Q30_W-1:0]              t_next;
    logic [32:0]                   s_round;
    logic [17:0]                   mag;
    logic [SIN_W-1:0]              mag_sat;
    logic signed [GAIN_W:0]        gain_sum;
    logic signed [32:0]            y_full;
    logic [SAMPLE_BITS-1:0]        y_sat;

    // Phase used for this item, and the folded quarter-wave position.
    assign phase_base = block_start ? '0 : phase_reg;
    assign addr       = phase_base[PHASE_W-1 -: SINE_ADDR_BITS];
    assign num        = addr[SINE_ADDR_BITS-2] ? (QUART - {1'b0, addr[QB-1:0]})
                                               : {1'b0, addr[QB-1:0]};
    assign x_next     = {num, {(PHASE_W-SINE_ADDR_BITS){1'b0}}};

    always_comb
    begin
        case (cmd.mul_op)
            MUL_X_X:
            begin
                op_a = {2'b00, x_reg};
                op_b = {2'b00, x_reg};
            end
            MUL_X2_C9:
            begin
                op_a = {2'b00, x2_reg};
                op_b = {2'b00, C9};
            end
            MUL_X2_T:
            begin
                op_a = {2'b00, x2_reg};
                op_b = {2'b00, t_reg};
            end
            MUL_X_T:
            begin
                op_a = {2'b00, x_reg};
                op_b = {2'b00, t_reg};
            end
            MUL_D_SIN:
            begin
                op_a = {{(MUL_W-DEPTH_W){1'b0}}, d_reg};
                op_b = MUL_W'(sin_reg);
            end
            MUL_SMP_GAIN:
            begin
                op_a = MUL_W'(smp_reg);
                op_b = MUL_W'(gain_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.wb_op)
            WB_T7:   coef = C7;
            WB_T5:   coef = C5;
            WB_T3:   coef = C3;
            WB_T1:   coef = C1;
            default: coef = '0;
        endcase
    end

    assign t_next = coef - prod_reg[60:30];

    // Round the Q30 sine to Q1.15 and clip at one.
    assign s_round = {1'b0, prod_reg[61:30]} + 33'd16384;
    assign mag     = s_round[32:15];
    assign mag_sat = (mag > 18'd32768) ? SIN_W'(DEPTH_MAX) : mag[SIN_W-1:0];

    // Arithmetic shifts of the signed products round toward minus infinity.
    assign gain_sum = (GAIN_W+1)'(signed'({1'b0, DEPTH_MAX - d_reg}))
                    + (GAIN_W+1)'($signed(prod_reg[31:15]));
    assign y_full   = $signed(prod_reg[47:15]);

    always_comb
    begin
        if (y_full > Y_HI)
            y_sat = Y_HI[SAMPLE_BITS-1:0];
        else if (y_full < Y_LO)
            y_sat = Y_LO[SAMPLE_BITS-1:0];
        else
            y_sat = y_full[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (cmd.load)
            phase_reg <= phase_base + {1'b0, phase_step};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= x_next;
            neg_reg <= addr[SINE_ADDR_BITS-1];
            d_reg   <= (depth > DEPTH_MAX) ? DEPTH_MAX : depth;
            smp_reg <= $signed(sample_in);
        end
        if (cmd.mul_op != MUL_NONE)
            prod_reg <= op_a * op_b;
        case (cmd.wb_op)
            WB_X2:   x2_reg   <= prod_reg[60:30];
            WB_T7,
            WB_T5,
            WB_T3,
            WB_T1:   t_reg    <= t_next;
            WB_SIN:  sin_reg  <= neg_reg ? -$signed(mag_sat) : $signed(mag_sat);
            WB_GAIN: gain_reg <= gain_sum[GAIN_W-1:0];
            WB_OUT:  out_reg  <= y_sat;
            default: ;
        endcase
    end

    assign sample_out = out_reg;

    `TAM_ASSERT_NEXT(a_x_range, clk, rst_n, cmd.load, x_reg <= Q30_ONE, "folded phase above one")
    `TAM_ASSERT_NEXT(a_sin_range, clk, rst_n, cmd.wb_op == WB_SIN, sin_reg <= 17'sd32768 && sin_reg >= -17'sd32768, "sine out of range")
    `TAM_ASSERT_NEXT(a_gain_range, clk, rst_n, cmd.wb_op == WB_GAIN, gain_reg <= 17'sd32768 && gain_reg >= -17'sd32768, "gain out of range")

endmodule

@@ test/tb_tremolo_amplitude_modulator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tremolo_amplitude_modulator
// Self-checking bench for the sine LFO tremolo modulator.
// ----------------------------------------------------------------------------
// A directed table covers the sample extremes, block restarts, register
// masking, depth at and above full and the saturated output at the negative
// sine peak. Random phases follow under several phase_step/depth settings.
// Each result is checked against its row's value if given, else a bit-exact
// local model of the phase accumulator, Q30 sine polynomial and Q1.15 gain path.
// ----------------------------------------------------------------------------
module tb_tremolo_amplitude_modulator;

    import trem_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  TAIL_CYCLES = 24;
    localparam int  PHASE_ITEMS = 200;
    localparam int  SINE_BITS   = 10;

    // Taylor coefficients of sin(pi/2 * x), Q30
    localparam longint unsigned SIN_K1 = 64'd1686629713;
    localparam longint unsigned SIN_K3 = 64'd693598668;
    localparam longint unsigned SIN_K5 = 64'd85569306;
    localparam longint unsigned SIN_K7 = 64'd5026995;
    localparam longint unsigned SIN_K9 = 64'd172272;

    typedef struct packed
    {
        logic        is_cfg;
        reg_idx_t    reg_sel;
        logic [31:0] value;    // register value, or sample_in in [23:0]
        logic        start;
        logic        typed;
        logic [23:0] result;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // sample_in
    logic        s_axis_tuser = 1'b0; // block_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // sample_out

    logic [31:0] phase_acc;
    logic [30:0] step_cfg;
    logic [15:0] depth_cfg;

    logic [23:0] expected_samples[$];
    stim_row_t   directed_rows[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    int          stall_odds = 4;
    int          gap_odds = 3;

    tremolo_amplitude_modulator i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sine value in Q1.15 for one table address.
    function automatic longint lfo_sine_q15(input logic [SINE_BITS-1:0] addr);
        longint unsigned span;
        longint unsigned pos;
        longint unsigned num;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned m;
        logic [1:0]      quad;
        span = 64'd1 << (SINE_BITS - 2);
        quad = addr[SINE_BITS-1 -: 2];
        pos  = 64'(addr[SINE_BITS-3:0]);
        num  = quad[0] ? span - pos : pos;
        x    = (num << 30) >> (SINE_BITS - 2);
        x2   = (x * x) >> 30;
        t    = SIN_K7 - ((x2 * SIN_K9) >> 30);
        t    = SIN_K5 - ((x2 * t) >> 30);
        t    = SIN_K3 - ((x2 * t) >> 30);
        t    = SIN_K1 - ((x2 * t) >> 30);
        s    = (x * t) >> 30;
        m    = (s + 64'd16384) >> 15;
        if (m > 64'd32768)
            m = 64'd32768;
        return quad[1] ? -longint'(m) : longint'(m);
    endfunction

    // Modulated sample for one accepted item; advances the LFO phase.
    function automatic logic [23:0] apply_tremolo(input logic [23:0] smp, input logic start);
        longint x;
        longint sine;
        longint d;
        longint gain;
        longint y;
        x = longint'($signed(smp));
        if (start)
            phase_acc = '0;
        sine = lfo_sine_q15(phase_acc[31 -: SINE_BITS]);
        d    = (depth_cfg > 16'd32768) ? 64'sd32768 : longint'(depth_cfg);
        gain = (64'sd32768 - d) + ((d * sine) >>> 15);
        y    = (x * gain) >>> 15;
        if (y > 64'sd8388607)
            y = 64'sd8388607;
        if (y < -64'sd8388608)
            y = -64'sd8388608;
        phase_acc = phase_acc + {1'b0, step_cfg};
        return y[23:0];
    endfunction

    function automatic void add_item(input logic [23:0] smp, input logic start,
                                     input logic typed, input logic [23:0] result);
        stim_row_t row;
        row = '{is_cfg: 1'b0, reg_sel: REG_PHASE_STEP, value: {8'h00, smp}, start: start,
                typed: typed, result: result};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input reg_idx_t sel, input logic [31:0] value);
        stim_row_t row;
        row = '{is_cfg: 1'b1, reg_sel: sel, value: value, start: 1'b0,
                typed: 1'b0, result: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_gap();
        if (gap_odds == 0)
            return 0;
        return ($urandom_range(0, gap_odds - 1) == 0) ? int'($urandom_range(1, 4)) : 0;
    endfunction

    // Result side: drop m_axis_tready in random bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
        begin
            stall_left    <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Check at the falling edge; the item moves at the next rising edge.
    always @(negedge clk)
    begin
        logic [23:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                $display("%0t: sample_out expected none, got %0d", $time,
                         $signed(m_axis_tdata));
            end
            else
            begin
                want = expected_samples.pop_front();
                if (m_axis_tdata !== want)
                begin
                    mismatches++;
                    $display("%0t: sample_out expected %0d, got %0d", $time,
                             $signed(want), $signed(m_axis_tdata));
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the item was taken
    // (or after the following gap).
    task automatic send_sample(input logic [23:0] smp, input logic start,
                               input logic typed, input logic [23:0] result);
        logic [23:0] predicted;
        int          gap;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= start;
        s_axis_tvalid <= 1'b1;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        predicted = apply_tremolo(smp, start);
        expected_samples.push_back(typed ? result : predicted);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the input until every pending result has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_samples.size() != 0);
    endtask

    // Setup and access phases, then idle before the next transfer.
    task automatic write_reg(input reg_idx_t sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_PHASE_STEP)
            step_cfg = value[30:0];
        else
            depth_cfg = value[15:0];
        @(posedge clk);
    endtask

    initial
    begin
        stim_row_t   row;
        logic [23:0] smp;
        logic        start;
        logic [31:0] step_val;
        logic [31:0] depth_val;

        phase_acc = '0;
        step_cfg  = '0;
        depth_cfg = 16'd16384;

        // Reset values: half gain at zero phase, so the result is floor(x / 2).
        add_item(24'h7FFFFF, 1'b1, 1'b1, 24'h3FFFFF);
        add_item(24'h800000, 1'b0, 1'b1, 24'hC00000);
        add_item(24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF);
        add_item(24'h000001, 1'b0, 1'b1, 24'h000000);
        add_item(24'h000000, 1'b0, 1'b1, 24'h000000);
        add_item(24'h555555, 1'b0, 1'b1, 24'h2AAAAA);
        add_item(24'hAAAAAA, 1'b0, 1'b1, 24'hD55555);
        // Zero depth passes samples through unchanged.
        add_cfg(REG_DEPTH, 32'h0000_0000);
        add_cfg(REG_PHASE_STEP, 32'h0123_4567);
        add_item(24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF);
        add_item(24'h800000, 1'b1, 1'b1, 24'h800000);
        add_item(24'hABCDEF, 1'b0, 1'b1, 24'hABCDEF);
        // Quarter-turn step (top bit masked off), depth above full.
        add_cfg(REG_PHASE_STEP, 32'hC000_0000);
        add_cfg(REG_DEPTH, 32'hFFFF_FFFF);
        add_item(24'h800000, 1'b1, 1'b1, 24'h000000);
        add_item(24'h7FFFFF, 1'b0, 1'b0, 24'h000000);
        add_item(24'h7FFFFF, 1'b0, 1'b1, 24'h000000);
        add_item(24'h800000, 1'b0, 1'b0, 24'h000000);   // negative peak: clamps
        add_item(24'h7FFFFF, 1'b0, 1'b0, 24'h000000);
        // Exactly full depth, largest step.
        add_cfg(REG_DEPTH, 32'h0000_8000);
        add_cfg(REG_PHASE_STEP, 32'h7FFF_FFFF);
        add_item(24'h400000, 1'b1, 1'b0, 24'h000000);
        add_item(24'hC00000, 1'b0, 1'b0, 24'h000000);
        add_item(24'h7FFFFF, 1'b0, 1'b0, 24'h000000);
        add_item(24'h800000, 1'b0, 1'b0, 24'h000000);
        // Just above full depth, one table step per sample.
        add_cfg(REG_DEPTH, 32'h0000_8001);
        add_cfg(REG_PHASE_STEP, 32'h0040_0000);
        add_item(24'h123456, 1'b0, 1'b0, 24'h000000);
        add_item(24'hEDCBA9, 1'b0, 1'b0, 24'h000000);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                drain_results();
                write_reg(row.reg_sel, row.value);
            end
            else
            begin
                send_sample(row.value[23:0], row.start, row.typed, row.result);
            end
        end

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:
                begin
                    step_val  = 32'h7FFF_FFFF;
                    depth_val = 32'h0000_8000;
                end
                1:
                begin
                    step_val  = 32'h0000_0000;
                    depth_val = 32'h0000_0000;
                end
                2:
                begin
                    step_val  = $urandom_range(0, 32'h00FF_FFFF);
                    depth_val = $urandom_range(0, 32768);
                end
                3:
                begin
                    step_val  = $urandom;
                    depth_val = 32'h0000_FFFF;
                end
                4:
                begin
                    step_val  = $urandom_range(0, 32'h000F_FFFF);
                    depth_val = $urandom;
                end
                default:
                begin
                    step_val  = $urandom;
                    depth_val = $urandom_range(0, 32768);
                end
            endcase
            // Vary which side idles; the last phase runs flat out.
            gap_odds   = (ph == 6 || ph % 3 == 1) ? 0 : 3;
            stall_odds = (ph == 6 || ph % 3 == 2) ? 0 : 4;
            drain_results();
            write_reg(REG_PHASE_STEP, step_val);
            write_reg(REG_DEPTH, depth_val);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 2 && i == PHASE_ITEMS / 2)
                    drain_results();
                case ($urandom_range(0, 15))
                    0:       smp = 24'h7FFFFF;
                    1:       smp = 24'h800000;
                    2:       smp = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
                    default: smp = 24'($urandom);
                endcase
                start = ($urandom_range(0, 31) == 0);
                send_sample(smp, start, 1'b0, 24'h000000);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
